>>> hw/rtl/fixed_slot_bag_table_defines.svh
// Assertion macros used by the checker file of the slot bag table.
`ifndef FIXED_SLOT_BAG_TABLE_DEFINES_SVH
`define FIXED_SLOT_BAG_TABLE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is held.
`define FSBT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define FSBT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/fsbt_pkg.sv
// Types, constants and helpers shared by the slot bag table modules.
`timescale 1ns / 1ps
package fsbt_pkg;

  localparam int SLOTS   = 16;
  localparam int VALUE_W = 32;
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 5;
  localparam int COUNT_MAX = 31;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int COUNT_LIMIT = (SLOTS > COUNT_MAX) ? COUNT_MAX : SLOTS;

  // Request queue between the front and the back.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Words that can be inside the block at once: queue, back end, output register.
  localparam int CAP     = QDEPTH + 2;
  localparam int OUTS_W  = $clog2(CAP + 1);

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_CHECK,
    OP_DELETE,
    OP_NONE
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_COMMIT
  } back_state_e;

  typedef struct packed {
    op_e                op;
    logic [VALUE_W-1:0] value;
  } fsbt_req_t;

  // Clamp the occupancy to what the count field can carry.
  function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    logic [31:0] wide;
    wide = 32'(c);
    if (wide > 32'(COUNT_MAX)) begin
      return COUNT_W'(COUNT_MAX);
    end
    return COUNT_W'(c);
  endfunction

endpackage

>>> hw/rtl/fixed_slot_bag_table.sv
// Top level of the slot bag table: front, request queue and back end.
`timescale 1ns / 1ps
// A bag of 16 slots of 32 bits, where a slot holding zero is empty; reset
// empties every slot at once, so the block takes words from the first cycle
// after reset with no clearing pass. Each input word names an operation
// (insert into the lowest empty slot, check membership, delete the lowest
// matching slot; any other kind code changes nothing) and a value, and gives
// exactly one result word with the success flag and the number of non-empty
// slots after the operation. The back end takes each word through ST_IDLE,
// which compares the value against all slots in parallel and registers the
// match vector, then ST_COMMIT, which picks the lowest match, updates the
// slot array and the running count, and loads the result register; it waits
// in ST_COMMIT while a result is stalled. So the back end takes a new word
// only after committing the last one, and a word passes the queue, the match
// and the result registers before its result shows. A two-entry queue sits
// between the input side and the back end, and the result register frees the
// back end on the same edge that a stalled result is taken. While a result
// waits, the back end can still take one word and the queue two more, so the
// input stalls only after three further words.
module fixed_slot_bag_table import fsbt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [KIND_W-1:0]         kind_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      ok_o,
  output logic [COUNT_W-1:0]        count_o
);

  // Front to queue.
  logic      push;
  logic      full;
  fsbt_req_t req;

  // Queue to back end.
  logic      q_valid;
  logic      q_pop;
  fsbt_req_t q_head;

  // Classifies the kind code and offers the word to the queue.
  fsbt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .full_i     (full),
    .push_o     (push),
    .req_o      (req)
  );

  // Holds up to two classified words until the back end is free.
  fsbt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (req),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  // Owns the slot array and produces the result words.
  fsbt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ok_o        (ok_o),
    .count_o     (count_o)
  );

endmodule

>>> hw/rtl/fsbt_front.sv
// Input side of the slot bag table: takes words and classifies the operation.
`timescale 1ns / 1ps
module fsbt_front import fsbt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [KIND_W-1:0]         kind_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      full_i,
  output logic                      push_o,
  output fsbt_req_t                 req_o
);

  op_e op;

  // Unused kind codes become a no-op that only reports the count.
  always_comb begin
    unique case (kind_i)
      KIND_INSERT: op = OP_INSERT;
      KIND_CHECK:  op = OP_CHECK;
      KIND_DELETE: op = OP_DELETE;
      default:     op = OP_NONE;
    endcase
  end

  assign in_stall_o  = full_i;
  assign push_o      = in_valid_i & ~full_i;
  assign req_o.op    = op;
  assign req_o.value = VALUE_W'(unsigned'(value_i));

  // The front holds no state of its own; clock and reset are kept for the
  // uniform port set of the block's parts.
  logic unused_ok;
  assign unused_ok = clk_i ^ rst_ni;

endmodule

>>> hw/rtl/fsbt_queue.sv
// Short request queue that decouples the front from the back.
`timescale 1ns / 1ps
module fsbt_queue import fsbt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  fsbt_req_t req_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output fsbt_req_t head_o
);

  fsbt_req_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_q, wr_d;
  logic [QPTR_W-1:0]  rd_q, rd_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= req_i;
    end
  end

endmodule

>>> hw/rtl/fsbt_back.sv
// Execution side of the slot bag table: slot array, match, commit and result register.
`timescale 1ns / 1ps
module fsbt_back import fsbt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  fsbt_req_t          q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               ok_o,
  output logic [COUNT_W-1:0] count_o
);

  back_state_e        state_q, state_d;
  logic [VALUE_W-1:0] slots_q [SLOTS];
  logic [VALUE_W-1:0] slots_d [SLOTS];
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  op_e                op_q;
  logic [VALUE_W-1:0] value_q;
  logic [SLOTS-1:0]   hit_q, hit_d, first;
  logic [VALUE_W-1:0] key;
  logic               found, nonzero, commit, out_free;
  logic               out_valid_q, out_valid_d;
  logic               ok_q, ok_d;
  logic [COUNT_W-1:0] count_q;

  // Insert looks for an empty slot; check and delete look for the value.
  always_comb begin
    key = (q_head_i.op == OP_INSERT) ? '0 : q_head_i.value;
    for (int i = 0; i < SLOTS; i++) begin
      hit_d[i] = (slots_q[i] == key);
    end
  end

  assign out_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        q_pop_o = q_valid_i;
        if (q_valid_i) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  assign first   = hit_q & (~hit_q + SLOTS'(1));
  assign found   = |hit_q;
  assign nonzero = |value_q;

  always_comb begin
    slots_d = slots_q;
    cnt_d   = cnt_q;
    ok_d    = found & (op_q != OP_NONE);
    if (op_q == OP_INSERT) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (first[i]) begin
          slots_d[i] = value_q;
        end
      end
      if (found && nonzero) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end else if (op_q == OP_DELETE) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (first[i]) begin
          slots_d[i] = '0;
        end
      end
      if (found && nonzero) begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slots_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        cnt_q   <= cnt_d;
        slots_q <= slots_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      op_q    <= q_head_i.op;
      value_q <= q_head_i.value;
      hit_q   <= hit_d;
    end
    if (commit) begin
      ok_q    <= ok_d;
      count_q <= sat_count(cnt_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign count_o     = count_q;

endmodule

>>> hw/rtl/fsbt_checker.sv
// Port-level checks for the slot bag table, bound to its top level.
`timescale 1ns / 1ps
`include "fixed_slot_bag_table_defines.svh"
module fsbt_checker import fsbt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_i,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input logic               ok_i,
  input logic [COUNT_W-1:0] count_i
);

  logic              in_acc, out_acc;
  logic [OUTS_W-1:0] outstanding_q;

  assign in_acc  = in_valid_i & ~in_stall_i;
  assign out_acc = out_valid_i & ~out_stall_i;

  // Words taken whose result has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else if (in_acc && !out_acc) begin
      outstanding_q <= outstanding_q + OUTS_W'(1);
    end else if (out_acc && !in_acc) begin
      outstanding_q <= outstanding_q - OUTS_W'(1);
    end
  end

  `FSBT_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i |=> out_valid_i && $stable(ok_i) && $stable(count_i), "stalled result changed")
  `FSBT_ASSERT(a_no_phantom, clk_i, rst_ni, out_valid_i |-> outstanding_q != '0, "result without a pending word")
  `FSBT_ASSERT(a_full_stalls, clk_i, rst_ni, outstanding_q == OUTS_W'(CAP) |-> in_stall_i, "input taken beyond capacity")
  `FSBT_ASSERT(a_count_range, clk_i, rst_ni, out_valid_i |-> count_i <= COUNT_W'(COUNT_LIMIT), "count above slot total")
  `FSBT_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_i, "result shown during reset")

endmodule

bind fixed_slot_bag_table fsbt_checker u_fsbt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .ok_i        (ok_o),
  .count_i     (count_o)
);

>>> test/testbench.sv
// Self-checking testbench for the slot bag table, with its own bag predictor.
`timescale 1ns / 1ps
module testbench;
  import fsbt_pkg::*;

  // One result word: success flag and occupancy after the operation.
  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] count;
  } bag_reply_t;

  // One row of stimulus. Rows marked known carry their result typed in;
  // the others take it from the predictor.
  typedef struct {
    op_e                op;
    logic [VALUE_W-1:0] value;
    bit                 known;
    logic               known_ok;
    logic [COUNT_W-1:0] known_count;
  } bag_row_t;

  localparam int DIRECTED_ROWS = 27;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [KIND_W-1:0] kind;
  logic signed [VALUE_W-1:0] value;
  logic out_valid;
  logic out_stall;
  logic ok;
  logic [COUNT_W-1:0] count;

  // Private copy of the slot array, updated as each input word is taken.
  logic [VALUE_W-1:0] bag_slots [SLOTS];
  bag_reply_t pending_replies [$];
  bag_row_t dir_rows [DIRECTED_ROWS];

  int mismatches = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  bit hold_pending = 1'b0;

  always #5 clk = ~clk;

  fixed_slot_bag_table u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .kind_i      (kind),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .ok_o        (ok),
    .count_o     (count)
  );

  task automatic flag_mismatch(input string what);
    $display("%0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Lowest slot that holds v, or -1 when no slot does.
  function automatic int lowest_slot_holding(input logic [VALUE_W-1:0] v);
    for (int i = 0; i < SLOTS; i++) begin
      if (bag_slots[i] == v) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Applies one request to the private bag and returns the result it yields.
  // A zero value acts on empty slots: insert and delete of zero succeed while
  // any slot is empty and leave the bag as it was.
  function automatic bag_reply_t bag_apply(input op_e op, input logic [VALUE_W-1:0] v);
    bag_reply_t r;
    int hit;
    int filled;
    r.ok = 1'b0;
    case (op)
      OP_INSERT: begin
        hit = lowest_slot_holding('0);
        if (hit >= 0) begin
          bag_slots[hit] = v;
          r.ok = 1'b1;
        end
      end
      OP_CHECK: begin
        r.ok = (lowest_slot_holding(v) >= 0);
      end
      OP_DELETE: begin
        hit = lowest_slot_holding(v);
        if (hit >= 0) begin
          bag_slots[hit] = '0;
          r.ok = 1'b1;
        end
      end
      default: begin
        // The unused kind changes nothing and reports failure.
      end
    endcase
    filled = 0;
    foreach (bag_slots[i]) begin
      if (bag_slots[i] != '0) begin
        filled++;
      end
    end
    if (filled > COUNT_MAX) begin
      filled = COUNT_MAX;
    end
    r.count = COUNT_W'(filled);
    return r;
  endfunction

  // Offers one word after a random gap and holds it until it is taken, then
  // records the result that it must produce.
  task automatic send_word(input bag_row_t row);
    bag_reply_t predicted;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= row.op;
    value    <= row.value;
    do begin
      @(posedge clk);
    end while (in_stall);
    predicted = bag_apply(row.op, row.value);
    if (row.known) begin
      predicted = '{row.known_ok, row.known_count};
    end
    pending_replies.push_back(predicted);
  endtask

  // Random words. The share of inserts swings between high and low every 40
  // words so the bag keeps filling to the top and draining again, and most
  // values come from a small pool so that checks and deletes find matches.
  task automatic random_burst(input int n);
    bag_row_t row;
    int pick;
    int insert_share;
    int i;
    insert_share = 20;
    row.known = 1'b0;
    row.known_ok = 1'b0;
    row.known_count = '0;
    for (i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        insert_share = (insert_share == 65) ? 20 : 65;
      end
      pick = $urandom_range(99);
      if (pick < insert_share) begin
        row.op = OP_INSERT;
      end else if (pick < insert_share + 3) begin
        row.op = OP_NONE;
      end else if ($urandom_range(1) == 1) begin
        row.op = OP_CHECK;
      end else begin
        row.op = OP_DELETE;
      end
      pick = $urandom_range(99);
      if (pick < 8) begin
        row.value = '0;
      end else if (pick < 72) begin
        row.value = VALUE_W'($urandom_range(12, 1));
      end else if (pick < 82) begin
        case ($urandom_range(2))
          0: row.value = 32'h8000_0000;
          1: row.value = 32'h7FFF_FFFF;
          default: row.value = 32'hFFFF_FFFF;
        endcase
      end else begin
        row.value = $urandom;
      end
      send_word(row);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request during which
  // the block fills up and must stall its input.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  // Every result word taken is compared with the oldest expectation.
  always @(posedge clk) begin
    bag_reply_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        flag_mismatch("result word arrived with none expected");
      end else begin
        due = pending_replies.pop_front();
        if (ok !== due.ok) begin
          flag_mismatch($sformatf("ok: got %b, expected %b", ok, due.ok));
        end
        if (count !== due.count) begin
          flag_mismatch($sformatf("count: got %0d, expected %0d", count, due.count));
        end
      end
    end
  end

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    kind     <= OP_INSERT;
    value    <= '0;
    foreach (bag_slots[i]) begin
      bag_slots[i] = '0;
    end

    // Empty bag, zero values, the unused kind, the value extremes, then the
    // bag is filled with duplicates until an insert fails on a full bag.
    dir_rows = '{
      '{OP_CHECK,  32'h0000_0000, 1'b1, 1'b1, 5'd0},
      '{OP_DELETE, 32'h0000_0007, 1'b1, 1'b0, 5'd0},
      '{OP_NONE,   32'h0000_0000, 1'b1, 1'b0, 5'd0},
      '{OP_INSERT, 32'h7FFF_FFFF, 1'b1, 1'b1, 5'd1},
      '{OP_INSERT, 32'h8000_0000, 1'b1, 1'b1, 5'd2},
      '{OP_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b1, 5'd3},
      '{OP_INSERT, 32'h0000_0000, 1'b1, 1'b1, 5'd3},
      '{OP_CHECK,  32'h8000_0000, 1'b1, 1'b1, 5'd3},
      '{OP_DELETE, 32'h7FFF_FFFF, 1'b1, 1'b1, 5'd2},
      '{OP_INSERT, 32'h0000_0001, 1'b1, 1'b1, 5'd3},
      '{OP_DELETE, 32'h0000_0000, 1'b1, 1'b1, 5'd3},
      '{OP_INSERT, 32'h5555_5555, 1'b1, 1'b1, 5'd4},
      '{OP_INSERT, 32'hAAAA_AAAA, 1'b1, 1'b1, 5'd5},
      '{OP_INSERT, 32'h5555_5555, 1'b1, 1'b1, 5'd6},
      '{OP_INSERT, 32'hAAAA_AAAA, 1'b1, 1'b1, 5'd7},
      '{OP_INSERT, 32'h5555_5555, 1'b1, 1'b1, 5'd8},
      '{OP_INSERT, 32'hAAAA_AAAA, 1'b1, 1'b1, 5'd9},
      '{OP_INSERT, 32'h5555_5555, 1'b1, 1'b1, 5'd10},
      '{OP_INSERT, 32'hAAAA_AAAA, 1'b1, 1'b1, 5'd11},
      '{OP_INSERT, 32'h5555_5555, 1'b1, 1'b1, 5'd12},
      '{OP_INSERT, 32'hAAAA_AAAA, 1'b1, 1'b1, 5'd13},
      '{OP_INSERT, 32'h5555_5555, 1'b1, 1'b1, 5'd14},
      '{OP_INSERT, 32'hAAAA_AAAA, 1'b1, 1'b1, 5'd15},
      '{OP_INSERT, 32'h5555_5555, 1'b1, 1'b1, 5'd16},
      '{OP_INSERT, 32'h1234_5678, 1'b1, 1'b0, 5'd16},
      '{OP_CHECK,  32'h0000_0000, 1'b1, 1'b0, 5'd16},
      '{OP_DELETE, 32'h5555_5555, 1'b0, 1'b0, 5'd0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    in_idle_pct  = 23;
    out_idle_pct = 51;
    foreach (dir_rows[r]) begin
      send_word(dir_rows[r]);
    end
    random_burst(470);

    in_idle_pct  = 51;
    out_idle_pct = 23;
    random_burst(470);

    // No idling on either side, opened by one long receiver hold-off.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_pending = 1'b1;
    random_burst(460);

    in_valid <= 1'b0;
    while (pending_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
